FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/hvsc_pkg.sv
// Package for the half-to-single vector converter: widths and encodings.
// No dependencies.
package hvsc_pkg;

    localparam int HALF_W   = 16;
    localparam int SINGLE_W = 32;

    localparam logic [4:0]  HALF_EXP_MAX  = 5'd31;
    localparam logic [7:0]  EXP_REBIAS    = 8'd112;  // 127 - 15
    localparam logic [7:0]  SUBN_EXP_BASE = 8'd103;  // 127 - 24
    localparam logic [4:0]  SUBN_SHIFT    = 5'd23;
    localparam logic [31:0] POS_MAX_HALF  = 32'h477F_E000;
    localparam logic [31:0] NEG_MAX_HALF  = 32'hC77F_E000;

endpackage

FILE: hw/rtl/hvsc_lane.sv
// One conversion lane: half-precision bit pattern to single-precision.
// Depends on hvsc_pkg.
module hvsc_lane (
    input  logic [hvsc_pkg::HALF_W-1:0]   half_in,
    output logic [hvsc_pkg::SINGLE_W-1:0] single_out
);
    import hvsc_pkg::*;

    logic        sign;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  lead_pos;
    logic [22:0] subn_mant;
    logic [7:0]  subn_exp;
    logic [7:0]  norm_exp;

    assign sign = half_in[15];
    assign ex   = half_in[14:10];
    assign man  = half_in[9:0];

    always_comb begin
        lead_pos = 4'd0;
        for (int k = 0; k < 10; k++) begin
            if (man[k]) begin
                lead_pos = 4'(k);
            end
        end
    end

    // leading one lands on bit 23 and falls off the 23-bit field
    assign subn_mant = {13'd0, man} << (SUBN_SHIFT - {1'b0, lead_pos});
    assign subn_exp  = SUBN_EXP_BASE + {4'd0, lead_pos};
    assign norm_exp  = {3'd0, ex} + EXP_REBIAS;

    always_comb begin
        if (ex == HALF_EXP_MAX) begin
            if (man == 10'd0) begin
                single_out = sign ? NEG_MAX_HALF : POS_MAX_HALF;
            end else begin
                single_out = '0;
            end
        end else if (ex == 5'd0) begin
            if (man == 10'd0) begin
                single_out = {sign, 31'd0};
            end else begin
                single_out = {sign, subn_exp, subn_mant};
            end
        end else begin
            single_out = {sign, norm_exp, man, 13'd0};
        end
    end

endmodule

FILE: hw/rtl/hvsc_out_stage.sv
// Output stage: merges lane results into one transaction, with a skid entry.
// No package dependencies.
module hvsc_out_stage #(
    parameter int DATA_W = 96
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DATA_W-1:0] skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

FILE: hw/rtl/half_vector_to_single_convert_top.sv
// Half-to-single vector converter: LANES parallel lanes and an output stage.
// Depends on hvsc_pkg, hvsc_lane, hvsc_out_stage.
// Each result is registered in the output stage (via the skid entry if stalled) before m_tdata.
// Throughput: one transaction per cycle while m_tready is high; set by the single output register stage.
// A stalled result is held while one more transaction is taken into the skid entry.
// Reset (aresetn low, synchronous) empties the output and skid entries.
module half_vector_to_single_convert_top #(
    parameter int LANES = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // x_half, y_half, z_half, ... (16 bits each, lane 0 lowest)
    input  logic [LANES*hvsc_pkg::HALF_W-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // x_single, y_single, z_single, ... (32 bits each, lane 0 lowest)
    output logic [LANES*hvsc_pkg::SINGLE_W-1:0] m_tdata
);
    import hvsc_pkg::*;

    logic [LANES*SINGLE_W-1:0] lane_data;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        hvsc_lane u_lane (
            .half_in    (s_tdata[i*HALF_W +: HALF_W]),
            .single_out (lane_data[i*SINGLE_W +: SINGLE_W])
        );
    end

    hvsc_out_stage #(
        .DATA_W (LANES*SINGLE_W)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (lane_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

FILE: hw/rtl/hvsc_checker.sv
// Port-level checker for the half-to-single vector converter, bound to the top.
// Depends on hvsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hvsc_checker #(
    parameter int LANES = 3
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [LANES*hvsc_pkg::SINGLE_W-1:0] m_tdata
);

    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    `ASSERT_CLK(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    `ASSERT_CLK(a_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "data moved")
    `ASSERT_CLK(a_empty_ready, aclk, aresetn, !m_tvalid |-> s_tready, "empty block stalls input")
    `ASSERT_CLK(a_one_cycle, aclk, aresetn, s_tvalid && s_tready && !m_tvalid |=> m_tvalid, "late")

endmodule

bind half_vector_to_single_convert_top hvsc_checker #(.LANES(LANES)) u_hvsc_checker (.*);

FILE: test/half_vector_to_single_convert_top_tb.sv
// Self-checking testbench for half_vector_to_single_convert_top: drives half vectors,
// predicts single-precision lanes in a scoreboard class and checks every result.
// Depends on hvsc_pkg and half_vector_to_single_convert_top.
module half_vector_to_single_convert_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANES = 3;
    localparam int HW = hvsc_pkg::HALF_W;
    localparam int SW = hvsc_pkg::SINGLE_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int LONG_HOLD_AT = 330;
    localparam int LONG_HOLD_CYCLES = 60;

    localparam logic [4:0]  EXP_ALL_ONES = 5'h1F;
    localparam logic [7:0]  NORMAL_REBIAS = 8'd112;
    localparam int          SUBNORMAL_BASE = 103;
    localparam logic [31:0] CLAMP_POS = 32'h477F_E000;
    localparam logic [31:0] CLAMP_NEG = 32'hC77F_E000;

    typedef logic [LANES*HW-1:0] halves_t;
    typedef logic [LANES*SW-1:0] singles_t;

    class conversion_scoreboard;
        singles_t pending_singles[$];
        int       fail_count;

        function new();
            fail_count = 0;
        endfunction

        static function logic [31:0] to_single(logic [15:0] h);
            logic        sign;
            logic [4:0]  ex;
            logic [9:0]  man;
            logic [22:0] frac;
            int          lead;
            sign = h[15];
            ex   = h[14:10];
            man  = h[9:0];
            if (ex == EXP_ALL_ONES) begin
                if (man != 0) return 32'h0;
                return sign ? CLAMP_NEG : CLAMP_POS;
            end
            if (ex == 5'd0) begin
                if (man == 0) return {sign, 31'h0};
                lead = 0;
                for (int k = 0; k < 10; k++)
                    if (man[k]) lead = k;
                // leading one shifts out past bit 22
                frac = 23'(man) << (23 - lead);
                return {sign, 8'(lead + SUBNORMAL_BASE), frac};
            end
            return {sign, 8'(ex) + NORMAL_REBIAS, man, 13'h0};
        endfunction

        function void note_input(halves_t halves);
            singles_t s;
            for (int i = 0; i < LANES; i++)
                s[i*SW +: SW] = to_single(halves[i*HW +: HW]);
            pending_singles.push_back(s);
        endfunction

        function void check_result(singles_t got);
            singles_t want;
            if (pending_singles.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                fail_count++;
                return;
            end
            want = pending_singles.pop_front();
            for (int i = 0; i < LANES; i++)
                if (got[i*SW +: SW] !== want[i*SW +: SW]) begin
                    $display("%0t: lane %0d expected %h actual %h", $time, i,
                             want[i*SW +: SW], got[i*SW +: SW]);
                    fail_count++;
                end
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_tvalid = 1'b0;
    logic     s_tready;
    halves_t  s_tdata = '0;
    logic     m_tvalid;
    logic     m_tready = 1'b0;
    singles_t m_tdata;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycle_count = 0;
    conversion_scoreboard board = new();

    half_vector_to_single_convert_top #(.LANES(LANES)) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("half_vector_to_single_convert_top test failed");
            $finish;
        end
    end

    // result side: checks transactions, then picks next tready
    initial begin : result_sink
        int  results_seen;
        int  hold_left;
        bit  long_hold_done;
        results_seen = 0;
        hold_left = 0;
        long_hold_done = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                board.check_result(m_tdata);
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                long_hold_done = 1;
                hold_left = LONG_HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // called right after a rising edge; returns at the accepting edge
    task automatic send_vector(input halves_t v);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        board.note_input(v);
    endtask

    function automatic logic [15:0] random_half();
        logic       sign;
        logic [9:0] man;
        int         shift;
        sign = 1'($urandom_range(1));
        case ($urandom_range(7))
            0, 1, 2: return 16'($urandom);
            3: return {sign, 15'h0};
            4: begin
                shift = $urandom_range(9);
                man = ((10'($urandom) & (10'h3FF >> shift)) | (10'h200 >> shift));
                return {sign, 5'h0, man};
            end
            5: return {sign, EXP_ALL_ONES, ($urandom_range(1) ? 10'h0 : 10'($urandom))};
            6: return {sign, ($urandom_range(1) ? 5'd1 : 5'd30), 10'($urandom)};
            default: return {sign, 5'($urandom_range(30, 1)), 10'($urandom)};
        endcase
    endfunction

    task automatic send_random(input int count);
        halves_t v;
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < LANES; i++)
                v[i*HW +: HW] = random_half();
            send_vector(v);
        end
    endtask

    initial begin : stimulus
        halves_t v;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zeros, subnormal ends, infinities, NaNs, normal ends
        send_vector({16'h0001, 16'h8000, 16'h0000});
        send_vector({16'h8001, 16'h8200, 16'h03FF});
        send_vector({16'h7E00, 16'hFC00, 16'h7C00});
        send_vector({16'hFFFF, 16'h7FFF, 16'hFC01});
        send_vector({16'hFBFF, 16'h7BFF, 16'h0400});
        send_vector({16'h3555, 16'hBC00, 16'h3C00});
        for (int k = 0; k < 10; k++) begin
            v = {{1'b0, 5'($urandom_range(30, 1)), 10'($urandom)},
                 16'h8000 | 16'((2 << k) - 1),
                 16'(1 << k)};
            send_vector(v);
        end
        send_vector({16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_vector({16'h0000, 16'h0000, 16'h0000});
        send_vector({16'h0F0F, 16'hAAAA, 16'h5555});

        tx_idle_pct = 20;
        rx_idle_pct = 62;
        send_random(RANDOM_PER_PHASE);
        tx_idle_pct = 62;
        rx_idle_pct = 20;
        send_random(RANDOM_PER_PHASE);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(RANDOM_PER_PHASE);
        s_tvalid <= 1'b0;

        while (board.pending_singles.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (board.fail_count == 0)
            $display("half_vector_to_single_convert_top test passed");
        else
            $display("half_vector_to_single_convert_top test failed");
        $finish;
    end
endmodule
